// ===== rtl/core/tfn_pkg.sv =====
package tfn_pkg;

   // Field widths
   localparam int CoordW  = 32;
   localparam int EdgeW   = CoordW + 1;
   localparam int ProdW   = 2 * EdgeW;
   localparam int CrossW  = ProdW + 1;
   localparam int MagW    = 65;
   localparam int LenW    = 7;
   localparam int RW      = 31;
   localparam int SqW     = 2 * RW;
   localparam int SumW    = 64;
   localparam int RootW   = 32;
   localparam int NormW   = 16;
   localparam int QuoW    = 15;
   localparam int RemW    = RootW + 2;

   // Pipeline depth
   localparam int SqrtSteps = RootW;
   localparam int DivSteps  = QuoW;
   localparam int Latency   = 7 + SqrtSteps + 1 + DivSteps + 1;

   // Side information that travels with each triangle
   typedef struct packed {
      logic                 last;
      logic                 deg;
      logic [2:0]           neg;
      logic [2:0][RW-1:0]   r;
   } side_type;

endpackage

// ===== rtl/core/triangle_face_normal.sv =====
// Flat face normal of a triangle, one triangle per clock.
//
// Input channel: a triangle (three Q16.16 vertices and a last mark) transfers
// at a rising edge where start is high and busy is low. Busy is always low,
// because the block is a fully pipelined datapath with no stalls, so a new
// triangle may be presented in every cycle.
// Result channel: each result is shown on the rsp_ ports for exactly one cycle
// with rsp_valid high. The receiver cannot stall, so nothing is held back.
// Each result passes through stages 1 to 7, the square root pipeline, the
// divider setup, the divider and the output register. Throughput is one
// triangle per cycle. The depth is set mostly by the 32-step square root
// pipeline and the 15-step restoring divider that produces the Q2.14 components.
// Reset (synchronous, active high) clears every stage valid bit, so triangles
// in flight are dropped and no result is shown until a new transfer has
// passed through. Payload registers are not reset.
// A triangle whose cross product is exactly zero gives a zero normal with
// rsp_degenerate set. rsp_last_out repeats req_last_in of the same triangle.
module triangle_face_normal
   import tfn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [CoordW-1:0] req_p1_x,
   input  logic signed [CoordW-1:0] req_p1_y,
   input  logic signed [CoordW-1:0] req_p1_z,
   input  logic signed [CoordW-1:0] req_p2_x,
   input  logic signed [CoordW-1:0] req_p2_y,
   input  logic signed [CoordW-1:0] req_p2_z,
   input  logic signed [CoordW-1:0] req_p3_x,
   input  logic signed [CoordW-1:0] req_p3_y,
   input  logic signed [CoordW-1:0] req_p3_z,
   input  logic                     req_last_in,
   output logic                     rsp_valid,
   output logic signed [NormW-1:0]  rsp_normal_x,
   output logic signed [NormW-1:0]  rsp_normal_y,
   output logic signed [NormW-1:0]  rsp_normal_z,
   output logic                     rsp_degenerate,
   output logic                     rsp_last_out
);

   // The datapath never stalls.
   assign busy = 1'b0;

   // Stage 1: edge vectors a = p1 - p3 and b = p2 - p3, exact at 33 bits.
   logic                    v1_ff, last1_ff;
   logic signed [EdgeW-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      last1_ff <= req_last_in;
      ax_ff <= EdgeW'(req_p1_x) - EdgeW'(req_p3_x);
      ay_ff <= EdgeW'(req_p1_y) - EdgeW'(req_p3_y);
      az_ff <= EdgeW'(req_p1_z) - EdgeW'(req_p3_z);
      bx_ff <= EdgeW'(req_p2_x) - EdgeW'(req_p3_x);
      by_ff <= EdgeW'(req_p2_y) - EdgeW'(req_p3_y);
      bz_ff <= EdgeW'(req_p2_z) - EdgeW'(req_p3_z);
   end

   // Stage 2: the six partial products of the cross product.
   logic                    v2_ff, last2_ff;
   logic signed [ProdW-1:0] p_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      last2_ff <= last1_ff;
      p_ff[0] <= ay_ff * bz_ff;
      p_ff[1] <= az_ff * by_ff;
      p_ff[2] <= az_ff * bx_ff;
      p_ff[3] <= ax_ff * bz_ff;
      p_ff[4] <= ax_ff * by_ff;
      p_ff[5] <= ay_ff * bx_ff;
   end

   // Stage 3: the cross product components, split into sign and magnitude.
   logic                    v3_ff, last3_ff;
   logic [2:0]              neg3_ff;
   logic [MagW-1:0]         mag3_ff [3];
   logic signed [CrossW-1:0] cr_in [3];
   logic [CrossW-1:0]       abs_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr_in[i]  = CrossW'(p_ff[2*i]) - CrossW'(p_ff[2*i+1]);
         abs_in[i] = cr_in[i][CrossW-1] ? CrossW'(-cr_in[i]) : CrossW'(cr_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      last3_ff <= last2_ff;
      for (int i = 0; i < 3; i++) begin
         neg3_ff[i] <= cr_in[i][CrossW-1];
         mag3_ff[i] <= abs_in[i][MagW-1:0];
      end
   end

   // Stage 4: bit length of the largest magnitude, which is the bit length
   // of the OR of all three.
   logic                    v4_ff, last4_ff;
   logic [2:0]              neg4_ff;
   logic [MagW-1:0]         mag4_ff [3];
   logic [LenW-1:0]         len4_ff;
   logic [MagW-1:0]         any_mag;
   logic [LenW-1:0]         len_in;

   always_comb begin
      any_mag = mag3_ff[0] | mag3_ff[1] | mag3_ff[2];
      len_in  = '0;
      for (int i = 0; i < MagW; i++) begin
         if (any_mag[i]) begin
            len_in = LenW'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      last4_ff <= last3_ff;
      neg4_ff  <= neg3_ff;
      mag4_ff  <= mag3_ff;
      len4_ff  <= len_in;
   end

   // Stage 5: scale so that the largest magnitude lies in [2^30, 2^31).
   logic                    v5_ff;
   side_type                side5_ff;
   logic [LenW-1:0]         rsh, lsh;
   logic [2:0][RW-1:0]      r_in;

   always_comb begin
      rsh = len4_ff - LenW'(RW);
      lsh = LenW'(RW) - len4_ff;
      for (int i = 0; i < 3; i++) begin
         if (len4_ff > LenW'(RW)) begin
            r_in[i] = RW'(mag4_ff[i] >> rsh);
         end else begin
            r_in[i] = RW'(mag4_ff[i] << lsh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      side5_ff.last <= last4_ff;
      side5_ff.deg  <= (len4_ff == '0);
      side5_ff.neg  <= neg4_ff;
      side5_ff.r    <= r_in;
   end

   // Stage 6: squares.
   logic                    v6_ff;
   side_type                side6_ff;
   logic [SqW-1:0]          sq6_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      side6_ff <= side5_ff;
      for (int i = 0; i < 3; i++) begin
         sq6_ff[i] <= SqW'(side5_ff.r[i]) * SqW'(side5_ff.r[i]);
      end
   end

   // Stage 7: sum of squares, which is the entry of the square root pipeline.
   logic                    sv_ff   [SqrtSteps+1];
   side_type                sside_ff[SqrtSteps+1];
   logic [SumW-1:0]         srem_ff [SqrtSteps+1];
   logic [SumW-1:0]         sres_ff [SqrtSteps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else begin
         sv_ff[0] <= v6_ff;
      end
      sside_ff[0] <= side6_ff;
      srem_ff[0]  <= SumW'(sq6_ff[0]) + SumW'(sq6_ff[1]) + SumW'(sq6_ff[2]);
      sres_ff[0]  <= '0;
   end

   // Square root: one result bit per stage, trial bit moving down by two.
   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      localparam logic [SumW-1:0] TrialBit = SumW'(1) << (SumW - 2 - 2 * k);
      logic [SumW-1:0] trial_in;

      assign trial_in = sres_ff[k] + TrialBit;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else begin
            sv_ff[k+1] <= sv_ff[k];
         end
         sside_ff[k+1] <= sside_ff[k];
         if (srem_ff[k] >= trial_in) begin
            srem_ff[k+1] <= srem_ff[k] - trial_in;
            sres_ff[k+1] <= (sres_ff[k] >> 1) + TrialBit;
         end else begin
            srem_ff[k+1] <= srem_ff[k];
            sres_ff[k+1] <= sres_ff[k] >> 1;
         end
      end
   end

   // Divider setup: q = (r * 2^15 + s) / (2 s). The high part of the
   // numerator is r + (s >> 15) and its low 15 bits are those of s.
   logic                    dv_ff   [DivSteps+1];
   side_type                dside_ff[DivSteps+1];
   logic [RootW-1:0]        droot_ff[DivSteps+1];
   logic [2:0][RemW-1:0]    drem_ff [DivSteps+1];
   logic [2:0][QuoW-1:0]    dquo_ff [DivSteps+1];
   logic [RootW-1:0]        root_in;

   assign root_in = sres_ff[SqrtSteps][RootW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= sv_ff[SqrtSteps];
      end
      dside_ff[0] <= sside_ff[SqrtSteps];
      droot_ff[0] <= root_in;
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] <= RemW'(sside_ff[SqrtSteps].r[i]) + RemW'(root_in >> QuoW);
         dquo_ff[0][i] <= '0;
      end
   end

   // Restoring division, one quotient bit per stage for all three lanes.
   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      logic [RemW-1:0]      divisor_in;
      logic [2:0][RemW-1:0] shifted_in;

      assign divisor_in = {1'b0, droot_ff[j], 1'b0};

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            shifted_in[i] = {drem_ff[j][i][RemW-2:0], droot_ff[j][QuoW-1-j]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else begin
            dv_ff[j+1] <= dv_ff[j];
         end
         dside_ff[j+1] <= dside_ff[j];
         droot_ff[j+1] <= droot_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (shifted_in[i] >= divisor_in) begin
               drem_ff[j+1][i] <= shifted_in[i] - divisor_in;
               dquo_ff[j+1][i] <= {dquo_ff[j][i][QuoW-2:0], 1'b1};
            end else begin
               drem_ff[j+1][i] <= shifted_in[i];
               dquo_ff[j+1][i] <= {dquo_ff[j][i][QuoW-2:0], 1'b0};
            end
         end
      end
   end

   // Output register: apply signs, force zero for a degenerate triangle.
   logic                    out_v_ff, out_deg_ff, out_last_ff;
   logic [2:0][NormW-1:0]   out_n_ff;
   logic [2:0][NormW-1:0]   n_in;
   side_type                fin;

   always_comb begin
      fin = dside_ff[DivSteps];
      for (int i = 0; i < 3; i++) begin
         if (fin.deg) begin
            n_in[i] = '0;
         end else if (fin.neg[i]) begin
            n_in[i] = NormW'(-NormW'(dquo_ff[DivSteps][i]));
         end else begin
            n_in[i] = NormW'(dquo_ff[DivSteps][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dv_ff[DivSteps];
      end
      out_deg_ff  <= fin.deg;
      out_last_ff <= fin.last;
      out_n_ff    <= n_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_normal_x   = out_n_ff[0];
   assign rsp_normal_y   = out_n_ff[1];
   assign rsp_normal_z   = out_n_ff[2];
   assign rsp_degenerate = out_deg_ff;
   assign rsp_last_out   = out_last_ff;

endmodule

// ===== rtl/core/tfn_checker.sv =====
module tfn_checker
   import tfn_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     req_last_in,
   input logic                     rsp_valid,
   input logic signed [NormW-1:0]  rsp_normal_x,
   input logic signed [NormW-1:0]  rsp_normal_y,
   input logic signed [NormW-1:0]  rsp_normal_z,
   input logic                     rsp_degenerate,
   input logic                     rsp_last_out
);

   // A result comes out only for a triangle that transferred a fixed time ago.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without matching transfer");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_out == $past(req_last_in, Latency))
      else $error("last mark out of step");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      else $error("degenerate normal not zero");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0)
      else $error("normal of a proper triangle is zero");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_last_in    (req_last_in),
   .rsp_valid      (rsp_valid),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_degenerate (rsp_degenerate),
   .rsp_last_out   (rsp_last_out)
);

// ===== tb/tfn_checker.sv =====
module tfn_scoreboard
   import tfn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic signed [CoordW-1:0] req_p1_x,
   input  logic signed [CoordW-1:0] req_p1_y,
   input  logic signed [CoordW-1:0] req_p1_z,
   input  logic signed [CoordW-1:0] req_p2_x,
   input  logic signed [CoordW-1:0] req_p2_y,
   input  logic signed [CoordW-1:0] req_p2_z,
   input  logic signed [CoordW-1:0] req_p3_x,
   input  logic signed [CoordW-1:0] req_p3_y,
   input  logic signed [CoordW-1:0] req_p3_z,
   input  logic                     req_last_in,
   input  logic                     rsp_valid,
   input  logic signed [NormW-1:0]  rsp_normal_x,
   input  logic signed [NormW-1:0]  rsp_normal_y,
   input  logic signed [NormW-1:0]  rsp_normal_z,
   input  logic                     rsp_degenerate,
   input  logic                     rsp_last_out,
   output int                       fail_count,
   output int                       pending,
   output int                       normals_seen,
   output int                       degenerate_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [NormW-1:0] nx;
      logic [NormW-1:0] ny;
      logic [NormW-1:0] nz;
      logic             deg;
      logic             last;
   } face_normal_type;

   face_normal_type normal_queue[$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic face_normal_type face_normal(
      input logic signed [31:0] ax1, ay1, az1, ax2, ay2, az2, ax3, ay3, az3,
      input logic last);
      face_normal_type res;
      logic signed [32:0] ex, ey, ez, fx, fy, fz;
      logic signed [67:0] n [3];
      logic [66:0] mag [3];
      logic [63:0] r [3];
      logic [63:0] sum, root, q;
      int len, shift;
      ex = 33'(ax1) - 33'(ax3);
      ey = 33'(ay1) - 33'(ay3);
      ez = 33'(az1) - 33'(az3);
      fx = 33'(ax2) - 33'(ax3);
      fy = 33'(ay2) - 33'(ay3);
      fz = 33'(az2) - 33'(az3);
      n[0] = 68'(ey) * 68'(fz) - 68'(ez) * 68'(fy);
      n[1] = 68'(ez) * 68'(fx) - 68'(ex) * 68'(fz);
      n[2] = 68'(ex) * 68'(fy) - 68'(ey) * 68'(fx);
      res = '0;
      res.last = last;
      len = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = n[i] < 0 ? 67'(-n[i]) : 67'(n[i]);
         for (int b = 0; b < 67; b++)
            if (mag[i][b] && b + 1 > len) len = b + 1;
      end
      if (len == 0) begin
         res.deg = 1'b1;
         return res;
      end
      shift = len - 31;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         r[i] = shift >= 0 ? 64'(mag[i] >> shift) : 64'(mag[i] << (-shift));
         sum = sum + r[i] * r[i];
      end
      root = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (r[i] * 64'd32768 + root) / (64'd2 * root);
         if (n[i] < 0) q = -q;
         if (i == 0) res.nx = q[15:0];
         else if (i == 1) res.ny = q[15:0];
         else res.nz = q[15:0];
      end
      return res;
   endfunction

   assign pending = normal_queue.size();

   initial begin
      fail_count = 0;
      normals_seen = 0;
      degenerate_seen = 0;
   end

   always @(posedge clock) begin
      face_normal_type want;
      face_normal_type got;
      if (!reset && start && !busy)
         normal_queue.push_back(face_normal(req_p1_x, req_p1_y, req_p1_z, req_p2_x,
            req_p2_y, req_p2_z, req_p3_x, req_p3_y, req_p3_z, req_last_in));
      if (!reset && rsp_valid) begin
         got = {rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate, rsp_last_out};
         normals_seen <= normals_seen + 1;
         if (rsp_degenerate) degenerate_seen <= degenerate_seen + 1;
         if (normal_queue.size() == 0) begin
            $display("%0t: unexpected result, got %h", $realtime, got);
            fail_count <= fail_count + 1;
         end else begin
            want = normal_queue.pop_front();
            if (want !== got) begin
               $display({"%0t: mismatch x/y/z/deg/last expected %0d %0d %0d %b %b,",
                         " actual %0d %0d %0d %b %b"},
                  $realtime, $signed(want.nx), $signed(want.ny), $signed(want.nz),
                  want.deg, want.last, rsp_normal_x, rsp_normal_y, rsp_normal_z,
                  rsp_degenerate, rsp_last_out);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tfn_pkg::*;

   localparam int StallLimit = 20 * Latency + 1000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [CoordW-1:0] p [9];
   logic last_in;
   logic rsp_valid;
   logic signed [NormW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate, rsp_last_out;
   int fail_count, pending, normals_seen, degenerate_seen;
   int idle_cycles;
   int triangles_sent;

   // The clock runs freely for the whole simulation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   triangle_face_normal i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_p1_x(p[0]), .req_p1_y(p[1]), .req_p1_z(p[2]),
      .req_p2_x(p[3]), .req_p2_y(p[4]), .req_p2_z(p[5]),
      .req_p3_x(p[6]), .req_p3_y(p[7]), .req_p3_z(p[8]),
      .req_last_in(last_in), .rsp_valid(rsp_valid),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate),
      .rsp_last_out(rsp_last_out)
   );

   tfn_scoreboard i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_p1_x(p[0]), .req_p1_y(p[1]), .req_p1_z(p[2]),
      .req_p2_x(p[3]), .req_p2_y(p[4]), .req_p2_z(p[5]),
      .req_p3_x(p[6]), .req_p3_y(p[7]), .req_p3_z(p[8]),
      .req_last_in(last_in), .rsp_valid(rsp_valid),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate),
      .rsp_last_out(rsp_last_out), .fail_count(fail_count), .pending(pending),
      .normals_seen(normals_seen), .degenerate_seen(degenerate_seen)
   );

   // The watchdog counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Picks one coordinate. Extremes, small values and full random words are mixed
   // so that large and tiny cross products both appear.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return 32'($signed($urandom_range(0, 64)) - 32);
         4, 5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   // Presents one triangle and holds it until it has been accepted.
   // The sender idles first with the requested probability.
   task automatic send_triangle(input logic [31:0] c [9], input logic last,
                                input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      for (int i = 0; i < 9; i++) p[i] <= c[i];
      last_in <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      triangles_sent++;
   endtask

   initial begin
      logic [31:0] c [9];
      int mode;
      idle_cycles = 0;
      triangles_sent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      last_in <= 1'b0;
      for (int i = 0; i < 9; i++) p[i] <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed triangles: a unit triangle, coordinate extremes, and several
      // degenerate shapes (all points equal, collinear, repeated vertex).
      for (int t = 0; t < 20; t++) begin
         for (int i = 0; i < 9; i++) c[i] = '0;
         case (t)
            0: begin c[0] = 32'h0001_0000; c[4] = 32'h0001_0000; end
            1: for (int i = 0; i < 9; i++) c[i] = 32'h8000_0000;
            2: for (int i = 0; i < 9; i++) c[i] = 32'h7fff_ffff;
            3: begin c[0] = 32'h7fff_ffff; c[4] = 32'h7fff_ffff;
                     for (int i = 6; i < 9; i++) c[i] = 32'h8000_0000; end
            4: begin c[0] = 32'h8000_0000; c[4] = 32'h7fff_ffff;
                     c[2] = 32'h7fff_ffff; c[5] = 32'h8000_0000; end
            5: begin c[0] = 1; c[3] = 2; end
            6: begin c[0] = 1; c[1] = 1; c[2] = 1; c[3] = 2; c[4] = 2; c[5] = 2; end
            7: begin c[0] = 1; c[5] = 1; end
            8: begin c[1] = 32'hffff_ffff; c[5] = 32'hffff_ffff; end
            9: begin c[0] = 32'h7fff_ffff; c[1] = 32'h8000_0000; c[2] = 32'h7fff_ffff;
                     c[3] = 32'h8000_0000; c[4] = 32'h7fff_ffff; c[5] = 32'h8000_0000; end
            10: for (int i = 0; i < 3; i++) c[i] = $urandom;
            default: for (int i = 0; i < 9; i++) c[i] = pick_coord();
         endcase
         send_triangle(c, t[0], 0);
      end

      // Random triangles in three idling phases: the sender idles now and
      // then, then often, then never. Some triangles reuse a vertex or are
      // collinear on purpose.
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < 300; n++) begin
            for (int i = 0; i < 9; i++) c[i] = pick_coord();
            mode = $urandom_range(0, 19);
            if (mode == 0) begin
               for (int i = 0; i < 3; i++) c[i + 3] = c[i];
            end else if (mode == 1) begin
               for (int i = 0; i < 3; i++) begin
                  c[i] = 32'($signed($urandom_range(0, 200)) - 100);
                  c[i + 6] = 0;
                  c[i + 3] = c[i] << 1;
               end
            end
            send_triangle(c, 1'($urandom), phase == 0 ? 31 : (phase == 1 ? 74 : 0));
         end
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      $display("sent %0d triangles, checked %0d normals, %0d of them degenerate",
               triangles_sent, normals_seen, degenerate_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tfn_pkg.sv
rtl/core/triangle_face_normal.sv
rtl/core/tfn_checker.sv
tb/tfn_checker.sv
tb/tb_top.sv
